/* rtl/lbpf_pkg.sv */
// Package for the linked block pool queues: field widths, operation codes,
// link entry and request types. No dependencies.
`default_nettype none

package lbpf_pkg;

  // Fixed field widths of the stream payload
  localparam int BLOCK_W   = 10;
  localparam int POOL_W    = 2;
  localparam int COUNT_W   = 11;
  localparam int MAX_BLOCK = 1 << BLOCK_W;   // block numbers the port can carry
  localparam int MAX_POOL  = 1 << POOL_W;    // pool numbers the port can carry

  // Operation codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // One successor link, or a head/tail pointer: valid flag plus block number
  typedef struct packed {
    logic               vld;
    logic [BLOCK_W-1:0] blk;
  } link_t;

  localparam link_t LINK_NULL = '{vld: 1'b0, blk: '0};

  // Latched request
  typedef struct packed {
    logic               act;
    logic [POOL_W-1:0]  pool;
    logic [BLOCK_W-1:0] blk;
  } req_t;

endpackage

`default_nettype wire

/* rtl/lbpf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                   clk,
  input  wire                                   we,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                       wdata,
  input  wire                                   re,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/linked_block_pool_fifo.sv */
// Linked block pool queues: FIFO pools of block numbers threaded through one link RAM.
// Result: registered in the execute state that follows an accepted request, and held back
//   while the previous result is still stalled on the result stream.
// Requests: no new request is taken until the previous one has executed, since the head
//   update of a pull waits on the link RAM read of the head's successor.
// Reset (rst, synchronous): empties all pools and clears control; the link RAM is not
//   cleared (a block's link is written when it is pushed), so there is no clearing pass.
// Depends on lbpf_pkg and lbpf_ram.
`default_nettype none

module linked_block_pool_fifo #(
  parameter int NUM_BLOCKS = 1024,
  parameter int NUM_POOLS  = 3
) (
  input  wire         clk,
  input  wire         rst,
  // Request stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [9:0] block
  input  wire  [2:0]  s_axis_tuser,   // [0] action, [2:1] pool
  // Result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [9:0] pulled_block, [20:10] pool_count
  output logic [0:0]  m_axis_tuser    // [0] pool_empty
);

  import lbpf_pkg::*;

  // Reachable storage follows from the parameters and the field widths
  localparam int MEM_DEPTH = NUM_BLOCKS < MAX_BLOCK ? NUM_BLOCKS : MAX_BLOCK;
  localparam int ADDR_W    = MEM_DEPTH > 1 ? $clog2(MEM_DEPTH) : 1;
  localparam int NP        = NUM_POOLS < MAX_POOL ? NUM_POOLS : MAX_POOL;
  localparam int PIDX_W    = NP > 1 ? $clog2(NP) : 1;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int LINK_W    = $bits(link_t);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state;
  req_t             req;
  link_t            head [NP];
  link_t            tail [NP];
  logic [CNT_W-1:0] size [NP];

  req_t              in_req;
  logic              in_accept;
  logic              in_pool_ok;
  logic              in_blk_ok;
  logic [PIDX_W-1:0] in_idx;

  logic              exec_go;
  logic              pool_ok;
  logic              blk_ok;
  logic [PIDX_W-1:0] idx;
  link_t             cur_head;
  link_t             cur_tail;
  logic [CNT_W-1:0]  cur_size;
  logic [LINK_W-1:0] rd_raw;
  link_t             rd_link;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  link_t             ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;

  link_t             head_next;
  link_t             tail_next;
  logic [CNT_W-1:0]  size_next;
  logic              upd;
  logic [BLOCK_W-1:0] res_pulled;
  logic              res_empty;
  logic [CNT_W-1:0]  res_count;

  // Input decode
  assign in_req     = '{act: s_axis_tuser[0], pool: s_axis_tuser[2:1],
                        blk: s_axis_tdata[BLOCK_W-1:0]};
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_pool_ok = 32'(in_req.pool) < NUM_POOLS;
  assign in_blk_ok  = 32'(in_req.blk) < NUM_BLOCKS;
  assign in_idx     = in_req.pool[PIDX_W-1:0];

  // Latched request decode
  assign exec_go  = (state == ST_EXEC) && (!m_axis_tvalid || m_axis_tready);
  assign pool_ok  = 32'(req.pool) < NUM_POOLS;
  assign blk_ok   = 32'(req.blk) < NUM_BLOCKS;
  assign idx      = req.pool[PIDX_W-1:0];
  assign cur_head = pool_ok ? head[idx] : LINK_NULL;
  assign cur_tail = pool_ok ? tail[idx] : LINK_NULL;
  assign cur_size = pool_ok ? size[idx] : '0;
  assign rd_link  = link_t'(rd_raw);

  // Head successor read, issued with the accepted request
  assign ram_raddr = in_pool_ok ? head[in_idx].blk[ADDR_W-1:0] : '0;

  // Link writes: clear the pushed block's link at accept; at execute either
  // chain the old tail to the pushed block or clear the pulled block's link
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_req.blk[ADDR_W-1:0];
    ram_wdata = LINK_NULL;
    if (in_accept && in_req.act == ACT_PUSH && in_pool_ok && in_blk_ok) begin
      ram_we = 1'b1;
    end else if (exec_go && pool_ok) begin
      if (req.act == ACT_PUSH && blk_ok && cur_tail.vld) begin
        ram_we    = 1'b1;
        ram_waddr = cur_tail.blk[ADDR_W-1:0];
        ram_wdata = '{vld: 1'b1, blk: req.blk};
      end else if (req.act == ACT_PULL && cur_head.vld) begin
        ram_we    = 1'b1;
        ram_waddr = cur_head.blk[ADDR_W-1:0];
      end
    end
  end

  lbpf_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MEM_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (ram_raddr),
    .rdata (rd_raw)
  );

  // Pool pointer and count update, and the result
  always_comb begin
    head_next  = cur_head;
    tail_next  = cur_tail;
    size_next  = cur_size;
    upd        = 1'b0;
    res_pulled = '0;
    res_empty  = 1'b0;
    if (!pool_ok) begin
      res_empty = req.act;
    end else if (req.act == ACT_PUSH) begin
      if (blk_ok) begin
        upd       = 1'b1;
        tail_next = '{vld: 1'b1, blk: req.blk};
        if (!cur_tail.vld) begin
          head_next = '{vld: 1'b1, blk: req.blk};
        end
        if (cur_size < CNT_W'(NUM_BLOCKS)) begin
          size_next = cur_size + CNT_W'(1);
        end
      end
    end else begin
      if (!cur_head.vld) begin
        res_empty = 1'b1;
      end else begin
        upd        = 1'b1;
        res_pulled = cur_head.blk;
        if (cur_tail.vld && cur_head.blk == cur_tail.blk) begin
          head_next = LINK_NULL;
          tail_next = LINK_NULL;
        end else begin
          head_next = rd_link;
        end
        if (cur_size != '0) begin
          size_next = cur_size - CNT_W'(1);
        end
      end
    end
    res_count = pool_ok ? size_next : '0;
  end

  // Control and pool registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NP; i++) begin
        head[i] <= LINK_NULL;
        tail[i] <= LINK_NULL;
        size[i] <= '0;
      end
    end else begin
      // result taken with no new one behind it
      if (m_axis_tready && !exec_go) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state         <= ST_IDLE;
            m_axis_tvalid <= 1'b1;
            if (upd) begin
              head[idx] <= head_next;
              tail[idx] <= tail_next;
              size[idx] <= size_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req <= in_req;
    end
    if (exec_go) begin
      m_axis_tdata <= {3'b000, COUNT_W'(res_count), res_pulled};
      m_axis_tuser <= res_empty;
    end
  end

`ifndef SYNTHESIS
  // No request is taken while one is still executing
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted during execute");

  // A new result only comes out of the execute step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_EXEC)
    else $error("result without execute");

  // An empty pull returns no block
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[BLOCK_W-1:0] == '0)
    else $error("empty pull returned a block");
`endif

endmodule

`default_nettype wire
